### rtl/rhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
`default_nettype none

package rhsv_pkg;

  // Hue and saturation result widths
  localparam int HUE_W = 9;
  localparam int SAT_W = 8;

  // Quotient bits produced by the divider pipeline (covers 0..255)
  localparam int QUOT_BITS = 8;

  // Hue base angles
  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_WRAP       = 9'd360;

  // Which channel is largest; SEC_NONE when all channels are equal
  typedef enum logic [1:0] {
    SEC_NONE  = 2'd0,
    SEC_RED   = 2'd1,
    SEC_GREEN = 2'd2,
    SEC_BLUE  = 2'd3
  } sector_t;

  // Bits of a classified item beyond its three color-wide fields
  localparam int CLS_EXTRA_BITS = $bits(sector_t) + 1;

endpackage

`default_nettype wire

### rtl/rhsv_in_if.sv
// Input channel interface: one RGB sample per transfer.
`default_nettype none

interface rhsv_in_if #(
  parameter int COLOR_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### rtl/rhsv_out_if.sv
// Result channel interface: one HSV result per transfer.
`default_nettype none

interface rhsv_out_if #(
  parameter int COLOR_BITS = 10
);
  import rhsv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [HUE_W-1:0]      hue;
  logic [SAT_W-1:0]      saturation;
  logic [COLOR_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness, output ready);
endinterface

`default_nettype wire

### rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front end, queue, divider back end.
//
//  channel | dir | fields                                  | handshake
//  --------+-----+-----------------------------------------+-------------------
//  in_if   | in  | red, green, blue (COLOR_BITS each)      | valid/ready
//  out_if  | out | hue (9), saturation (8), brightness     | valid/ready
//
// Throughput is one sample per clock while out_if takes results; every transfer
// starts a new conversion. From input transfer to result valid a sample passes
// the queue, the numerator stage, eight restoring-divide stages (one quotient
// bit each) and the result register; the queue is written at the transfer edge.
// Reset (rst_n low, synchronous) empties the queue and the pipeline.
// A stall on out_if freezes the divider pipeline; the queue keeps taking
// samples until it holds Q_DEPTH items, then in_if.ready drops.
`default_nettype none

module rgb_to_hsv_converter #(
  parameter int COLOR_BITS = 10,
  parameter int Q_DEPTH    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  rhsv_in_if.sink    in_if,
  rhsv_out_if.source out_if
);
  import rhsv_pkg::*;

  // classified item: sector, sign, |diff|, span, max
  localparam int CLS_W = 3 * COLOR_BITS + CLS_EXTRA_BITS;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [CLS_W-1:0] q_wdata;
  logic [CLS_W-1:0] q_rdata;

  // max/min search, sector pick and hue difference, all in the accept cycle
  rhsv_front #(
    .COLOR_BITS (COLOR_BITS),
    .CLS_W      (CLS_W)
  ) u_front (
    .in_if   (in_if),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // decouples input acceptance from result back-pressure
  rhsv_queue #(
    .DW    (CLS_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // hue and saturation quotients, hue offset/wrap, result register
  rhsv_back #(
    .COLOR_BITS (COLOR_BITS),
    .CLS_W      (CLS_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

### rtl/rhsv_front.sv
// Front end: accepts samples, finds max/min/sector and the hue difference.
`default_nettype none

module rhsv_front #(
  parameter int COLOR_BITS = 10,
  parameter int CLS_W      = 3 * 10 + 3
) (
  rhsv_in_if.sink          in_if,
  input  logic             q_full,
  output logic             q_push,
  output logic [CLS_W-1:0] q_wdata
);
  import rhsv_pkg::*;

  typedef struct packed {
    sector_t               sector;
    logic                  neg;
    logic [COLOR_BITS-1:0] absdiff;
    logic [COLOR_BITS-1:0] span;
    logic [COLOR_BITS-1:0] mx;
  } cls_t;

  cls_t                  cls;
  logic [COLOR_BITS-1:0] mn;
  logic [COLOR_BITS-1:0] op_a;
  logic [COLOR_BITS-1:0] op_b;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    // largest channel, ties go red, then green, then blue
    if (in_if.red >= in_if.green && in_if.red >= in_if.blue) begin
      cls.mx     = in_if.red;
      cls.sector = SEC_RED;
      op_a       = in_if.green;
      op_b       = in_if.blue;
    end else if (in_if.green >= in_if.blue) begin
      cls.mx     = in_if.green;
      cls.sector = SEC_GREEN;
      op_a       = in_if.blue;
      op_b       = in_if.red;
    end else begin
      cls.mx     = in_if.blue;
      cls.sector = SEC_BLUE;
      op_a       = in_if.red;
      op_b       = in_if.green;
    end

    if (in_if.red <= in_if.green && in_if.red <= in_if.blue) begin
      mn = in_if.red;
    end else if (in_if.green <= in_if.blue) begin
      mn = in_if.green;
    end else begin
      mn = in_if.blue;
    end

    cls.span = cls.mx - mn;
    if (cls.span == '0) begin
      cls.sector = SEC_NONE;
    end

    // sign and magnitude of the hue difference
    cls.neg     = op_a < op_b;
    cls.absdiff = cls.neg ? (op_b - op_a) : (op_a - op_b);
  end

  assign q_wdata = cls;

endmodule

`default_nettype wire

### rtl/rhsv_queue.sv
// Small FIFO between the classify front end and the divider back end.
`default_nettype none

module rhsv_queue #(
  parameter int DW    = 33,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

`default_nettype wire

### rtl/rhsv_back.sv
// Back end: pipelined restoring divider for hue and saturation, result register.
`default_nettype none

module rhsv_back #(
  parameter int COLOR_BITS = 10,
  parameter int CLS_W      = 3 * 10 + 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CLS_W-1:0] q_rdata,
  input  logic             q_empty,
  output logic             q_pop,
  rhsv_out_if.source       out_if
);
  import rhsv_pkg::*;

  localparam int RW  = COLOR_BITS + QUOT_BITS;  // numerator < 256 * divisor
  localparam int NST = QUOT_BITS + 1;           // numerator stage + one per bit

  typedef struct packed {
    sector_t               sector;
    logic                  neg;
    logic [COLOR_BITS-1:0] absdiff;
    logic [COLOR_BITS-1:0] span;
    logic [COLOR_BITS-1:0] mx;
  } cls_t;

  typedef struct packed {
    sector_t               sector;
    logic                  neg;
    logic [COLOR_BITS-1:0] span;
    logic [COLOR_BITS-1:0] mx;
    logic [RW-1:0]         rem_h;
    logic [RW-1:0]         rem_s;
    logic [QUOT_BITS-1:0]  q_h;
    logic [QUOT_BITS-1:0]  q_s;
  } stage_t;

  cls_t                  head;
  logic                  adv;
  stage_t                st_r   [NST];
  stage_t                st_nxt [NST];
  logic [NST-1:0]        vld_r, vld_nxt;
  stage_t                last;
  logic [HUE_W-1:0]      q_h9;
  logic [HUE_W-1:0]      hue_nxt;
  logic [SAT_W-1:0]      sat_nxt;
  logic                  out_vld_r;
  logic [HUE_W-1:0]      hue_r;
  logic [SAT_W-1:0]      sat_r;
  logic [COLOR_BITS-1:0] bright_r;

  assign head  = q_rdata;
  // whole pipeline moves when the result register is free or being drained
  assign adv   = !out_vld_r || out_if.ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    logic [RW-1:0] dh;
    logic [RW-1:0] ds;

    // numerators: 60*|diff| = 64x - 4x, 255*span = 256x - x
    st_nxt[0].sector = head.sector;
    st_nxt[0].neg    = head.neg;
    st_nxt[0].span   = head.span;
    st_nxt[0].mx     = head.mx;
    st_nxt[0].rem_h  = (RW'(head.absdiff) << 6) - (RW'(head.absdiff) << 2);
    st_nxt[0].rem_s  = (RW'(head.span) << 8) - RW'(head.span);
    st_nxt[0].q_h    = '0;
    st_nxt[0].q_s    = '0;
    vld_nxt[0]       = !q_empty;

    // one quotient bit per stage, MSB first
    for (int i = 1; i < NST; i++) begin
      st_nxt[i]  = st_r[i-1];
      vld_nxt[i] = vld_r[i-1];
      dh = RW'(st_r[i-1].span) << (QUOT_BITS - i);
      ds = RW'(st_r[i-1].mx)   << (QUOT_BITS - i);
      if (st_r[i-1].rem_h >= dh) begin
        st_nxt[i].rem_h               = st_r[i-1].rem_h - dh;
        st_nxt[i].q_h[QUOT_BITS - i]  = 1'b1;
      end
      if (st_r[i-1].rem_s >= ds) begin
        st_nxt[i].rem_s               = st_r[i-1].rem_s - ds;
        st_nxt[i].q_s[QUOT_BITS - i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // hue offset and wrap, saturation zero guard
  assign last = st_r[NST-1];
  assign q_h9 = HUE_W'(last.q_h);

  always_comb begin
    case (last.sector)
      SEC_RED: begin
        hue_nxt = (last.neg && q_h9 != '0) ? (HUE_WRAP - q_h9) : q_h9;
      end
      SEC_GREEN: begin
        hue_nxt = last.neg ? (HUE_GREEN_BASE - q_h9) : (HUE_GREEN_BASE + q_h9);
      end
      SEC_BLUE: begin
        hue_nxt = last.neg ? (HUE_BLUE_BASE - q_h9) : (HUE_BLUE_BASE + q_h9);
      end
      default: begin
        hue_nxt = '0;
      end
    endcase
    sat_nxt = (last.mx == '0) ? '0 : SAT_W'(last.q_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= last.mx;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.hue        = hue_r;
  assign out_if.saturation = sat_r;
  assign out_if.brightness = bright_r;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> hue_r < HUE_WRAP)
    else $error("hue out of range");

  a_sat_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && bright_r == '0 |-> sat_r == '0)
    else $error("saturation nonzero for black sample");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("divider pipeline moved while stalled");

endmodule

`default_nettype wire

### dv/tb_rgb_to_hsv_converter.sv
// Self-checking testbench for rgb_to_hsv_converter: directed corners, random samples, backpressure.
`default_nettype none

module tb_rgb_to_hsv_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import rhsv_pkg::*;

  localparam int COLOR_BITS   = 10;
  localparam int CHAN_MAX     = (1 << COLOR_BITS) - 1;
  localparam int PIPE_LATENCY = 10;    // input transfer to result valid
  localparam int LONG_HOLD    = 200;   // cycles the result side holds off once
  localparam int STALL_LIMIT  = 2000;  // cycles without any transfer before giving up

  // One expected conversion; the sample is kept for the mismatch printout.
  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [HUE_W-1:0]      hue;
    logic [SAT_W-1:0]      sat;
    logic [COLOR_BITS-1:0] bright;
  } hsv_expect_t;

  logic clk;
  logic rst_n;

  rhsv_in_if  #(.COLOR_BITS(COLOR_BITS)) in_ch ();
  rhsv_out_if #(.COLOR_BITS(COLOR_BITS)) out_ch ();

  rgb_to_hsv_converter #(.COLOR_BITS(COLOR_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  hsv_expect_t expected_hsv_q[$];
  int          mismatch_count;
  int          quiet_cycles;
  bit          idle_enable;   // random gaps on both sides
  int          hold_reqs;     // long hold-offs requested of the result side

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: integer HSV of one sample. Ties for the largest channel go to
  // red, then green, then blue; hue division truncates toward zero and a
  // negative hue (red largest, blue above green) wraps by adding 360.
  // ---------------------------------------------------------------------------
  function automatic hsv_expect_t predict_hsv(input logic [COLOR_BITS-1:0] r, g, b);
    int          red, grn, blu;
    int          top, bottom, span, angle, sat;
    sector_t     sector;
    hsv_expect_t res;
    red = int'(r);
    grn = int'(g);
    blu = int'(b);
    top = red;
    if (grn > top) top = grn;
    if (blu > top) top = blu;
    bottom = red;
    if (grn < bottom) bottom = grn;
    if (blu < bottom) bottom = blu;
    span = top - bottom;

    if (span == 0) sector = SEC_NONE;
    else if (top == red) sector = SEC_RED;
    else if (top == grn) sector = SEC_GREEN;
    else sector = SEC_BLUE;

    // int'() keeps the base angles from turning the division unsigned
    case (sector)
      SEC_RED:   angle = (60 * (grn - blu)) / span;
      SEC_GREEN: angle = (60 * (blu - red)) / span + int'(HUE_GREEN_BASE);
      SEC_BLUE:  angle = (60 * (red - grn)) / span + int'(HUE_BLUE_BASE);
      default:   angle = 0;
    endcase
    if (angle < 0) angle += int'(HUE_WRAP);

    // all-zero sample: saturation is 0 rather than a division by zero
    sat = (top == 0) ? 0 : (255 * span) / top;

    res.red    = r;
    res.green  = g;
    res.blue   = b;
    res.hue    = angle[HUE_W-1:0];
    res.sat    = sat[SAT_W-1:0];
    res.bright = top[COLOR_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Both channels are sampled at the rising edge, before any
  // nonblocking update of that edge lands, so a transfer is exactly
  // valid && ready as seen by the DUT's own flops.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hsv_expect_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hsv_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result hue=%0d sat=%0d bright=%0d",
                                    out_ch.hue, out_ch.saturation, out_ch.brightness));
        end else begin
          want = expected_hsv_q.pop_front();
          if (out_ch.hue !== want.hue)
            report_mismatch($sformatf("hue for rgb=(%0d,%0d,%0d): expected %0d, got %0d",
                                      want.red, want.green, want.blue, want.hue, out_ch.hue));
          if (out_ch.saturation !== want.sat)
            report_mismatch($sformatf("saturation for rgb=(%0d,%0d,%0d): expected %0d, got %0d",
                                      want.red, want.green, want.blue, want.sat,
                                      out_ch.saturation));
          if (out_ch.brightness !== want.bright)
            report_mismatch($sformatf("brightness for rgb=(%0d,%0d,%0d): expected %0d, got %0d",
                                      want.red, want.green, want.blue, want.bright,
                                      out_ch.brightness));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_hsv_q.push_back(predict_hsv(in_ch.red, in_ch.green, in_ch.blue));
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_hsv_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random stall bursts, plus one long hold-off on
  // request, counted here. At most one assignment to ready per edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_reqs != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one sample, maybe after an idle burst, and wait for its transfer.
  // valid stays high afterward so back-to-back samples need no extra edge.
  task automatic send_rgb(input logic [COLOR_BITS-1:0] r, g, b);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.red   <= r;
    in_ch.green <= g;
    in_ch.blue  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_hsv_q.size() != 0) @(posedge clk);
  endtask

  // Random sample, weighted toward ties, near-gray and extreme values.
  task automatic pick_sample(output logic [COLOR_BITS-1:0] r, g, b);
    logic [COLOR_BITS-1:0] base;
    base = COLOR_BITS'($urandom_range(0, CHAN_MAX));
    r = COLOR_BITS'($urandom_range(0, CHAN_MAX));
    g = COLOR_BITS'($urandom_range(0, CHAN_MAX));
    b = COLOR_BITS'($urandom_range(0, CHAN_MAX));
    case ($urandom_range(0, 7))
      4: begin  // near gray: tiny span, hue rounding edge
        r = base;
        g = base ^ COLOR_BITS'($urandom_range(0, 3));
        b = base ^ COLOR_BITS'($urandom_range(0, 3));
      end
      5: begin  // two channels share a value
        case ($urandom_range(0, 2))
          0:       g = r;
          1:       b = g;
          default: b = r;
        endcase
      end
      6: begin  // each channel at zero or full scale
        r = $urandom_range(0, 1) ? COLOR_BITS'(CHAN_MAX) : '0;
        g = $urandom_range(0, 1) ? COLOR_BITS'(CHAN_MAX) : '0;
        b = $urandom_range(0, 1) ? COLOR_BITS'(CHAN_MAX) : '0;
      end
      7: begin  // dark samples
        r = COLOR_BITS'($urandom_range(0, 7));
        g = COLOR_BITS'($urandom_range(0, 7));
        b = COLOR_BITS'($urandom_range(0, 7));
      end
      default: ;
    endcase
  endtask

  task automatic send_random(input int count);
    logic [COLOR_BITS-1:0] r, g, b;
    repeat (count) begin
      pick_sample(r, g, b);
      send_rgb(r, g, b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners: gray, each channel largest, every tie, wrap, truncation.
  task automatic test_directed();
    idle_enable = 1'b0;
    send_rgb(0, 0, 0);                   // black, no divide by zero
    send_rgb(1023, 1023, 1023);          // white
    send_rgb(512, 512, 512);             // mid gray
    send_rgb(1023, 0, 0);                // pure red
    send_rgb(0, 1023, 0);                // pure green
    send_rgb(0, 0, 1023);                // pure blue
    send_rgb(1023, 1023, 0);             // red/green tie -> red
    send_rgb(0, 1023, 1023);             // green/blue tie -> green
    send_rgb(1023, 0, 1023);             // red/blue tie -> red, wraps to 300
    send_rgb(1023, 0, 500);              // negative hue wraps
    send_rgb(1000, 0, 17);               // wraps to 359
    send_rgb(1000, 0, 1);                // -0.06 truncates to 0
    send_rgb(1, 0, 0);                   // full saturation at the bottom
    send_rgb(1023, 1022, 1022);          // span of one
    send_rgb(682, 341, 1023);            // blue largest
    send_rgb(10'h2AA, 10'h155, 10'h2AA); // alternating bits
    send_rgb(10'h155, 10'h2AA, 10'h155);
    send_rgb(5, 900, 3);
    send_rgb(700, 701, 702);
    send_rgb(1022, 1023, 0);
    drain_results();
  endtask

  // Random samples with idling switched on and off in stretches.
  task automatic test_random_idling();
    for (int chunk = 0; chunk < 6; chunk++) begin
      idle_enable = (chunk % 3) != 2;
      send_random(55);
    end
    drain_results();
  endtask

  // Result side holds off long enough that the queue fills and input stalls.
  task automatic test_backpressure();
    idle_enable = 1'b0;
    hold_reqs++;
    send_random(40);
    drain_results();
  endtask

  // Sender waits for every result before each short burst.
  task automatic test_sender_pause();
    idle_enable = 1'b1;
    repeat (6) begin
      send_random(10);
      drain_results();
    end
  endtask

  // Last part: full rate, no gaps on either side.
  task automatic test_full_rate();
    idle_enable = 1'b0;
    send_random(310);
    drain_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.red      = '0;
    in_ch.green    = '0;
    in_ch.blue     = '0;
    idle_enable    = 1'b0;
    hold_reqs      = 0;
    mismatch_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_idling();
    test_backpressure();
    test_sender_pause();
    test_full_rate();

    // catch any stray result the pipeline might still emit
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (expected_hsv_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_hsv_q.size()));

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/rhsv_pkg.sv
rtl/rhsv_in_if.sv
rtl/rhsv_out_if.sv
rtl/rhsv_front.sv
rtl/rhsv_queue.sv
rtl/rhsv_back.sv
rtl/rgb_to_hsv_converter.sv
dv/tb_rgb_to_hsv_converter.sv
